// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQH_ASSERT_IMPLY(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sqh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SQH_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sqh assertion failed");

`endif

// File: rtl/sqh_pkg.sv
package sqh_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int HISTORY_DEPTH = 16;
    localparam int ID_BITS       = 16;

    localparam int ID_PORT_W  = 16;
    localparam int AGE_W      = 7;
    localparam int GAP_CFG_W  = 5;
    localparam int CNT_PORT_W = 5;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QSUM_W = QCNT_W + 1;
    localparam int HPTR_W = $clog2(HISTORY_DEPTH);
    localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SCAN_W = $clog2(QUEUE_DEPTH + HISTORY_DEPTH + 1);
    localparam int GAP_W  = (QCNT_W > GAP_CFG_W) ? QCNT_W : GAP_CFG_W;

    // commands
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_SERVE = 2'd1;
    localparam logic [1:0] CMD_UNDO  = 2'd2;

    // status codes
    localparam logic [3:0] ST_OK     = 4'd0;
    localparam logic [3:0] ST_DUP    = 4'd1;
    localparam logic [3:0] ST_YOUNG  = 4'd2;
    localparam logic [3:0] ST_OLD    = 4'd3;
    localparam logic [3:0] ST_GAP    = 4'd4;
    localparam logic [3:0] ST_QEMPTY = 4'd5;
    localparam logic [3:0] ST_HEMPTY = 4'd6;
    localparam logic [3:0] ST_QFULL  = 4'd7;
    localparam logic [3:0] ST_HFULL  = 4'd8;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_AGE = 2'd0;
    localparam logic [1:0] REG_MAX_AGE = 2'd1;
    localparam logic [1:0] REG_GAP     = 2'd2;

    localparam logic [AGE_W-1:0]     MIN_AGE_RST = 7'd18;
    localparam logic [AGE_W-1:0]     MAX_AGE_RST = 7'd100;
    localparam logic [GAP_CFG_W-1:0] GAP_RST     = 5'd3;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [AGE_W-1:0]   age;
        logic               cls;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [AGE_W-1:0]     min_age;
        logic [AGE_W-1:0]     max_age;
        logic [GAP_CFG_W-1:0] gap;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [QPTR_W-1:0] waddr;
        logic [QPTR_W-1:0] raddr;
        entry_t            wdata;
    } qmem_req_t;

    typedef struct packed {
        logic              we;
        logic [HPTR_W-1:0] waddr;
        logic [HPTR_W-1:0] raddr;
        entry_t            wdata;
    } hmem_req_t;

    typedef struct packed {
        logic [3:0]        status;
        entry_t            moved;
        logic [QCNT_W-1:0] waiting;
        logic [HCNT_W-1:0] history;
        logic [QCNT_W-1:0] men;
        logic [QCNT_W-1:0] women;
    } rsp_t;

    // Queue slot base + k, wrapped once; base < depth and k <= depth.
    function automatic logic [QPTR_W-1:0] qwrap(input logic [QPTR_W-1:0] base,
                                                input logic [QCNT_W-1:0] k);
        logic [QSUM_W-1:0] sum;
        sum = QSUM_W'(base) + QSUM_W'(k);
        if (sum >= QSUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - QSUM_W'(QUEUE_DEPTH);
        end
        return sum[QPTR_W-1:0];
    endfunction

    // Port id to stored id width.
    function automatic logic [ID_BITS-1:0] id_in(input logic [ID_PORT_W-1:0] x);
        logic [ID_BITS+ID_PORT_W-1:0] t;
        t = {{ID_BITS{1'b0}}, x};
        return t[ID_BITS-1:0];
    endfunction

    // Stored id to port width.
    function automatic logic [ID_PORT_W-1:0] id_out(input logic [ID_BITS-1:0] x);
        logic [ID_BITS+ID_PORT_W-1:0] t;
        t = {{ID_PORT_W{1'b0}}, x};
        return t[ID_PORT_W-1:0];
    endfunction

endpackage

// File: rtl/sqh_ram.sv
module sqh_ram
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/sqh_ctrl.sv
module sqh_ctrl
    import sqh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           command,
    input  logic [ID_PORT_W-1:0] entry_id,
    input  logic [AGE_W-1:0]     entry_age,
    input  logic                 entry_class,
    input  cfg_t                 cfg,
    output qmem_req_t            qreq,
    input  entry_t               qrd,
    output hmem_req_t            hreq,
    input  entry_t               hrd,
    output logic                 busy,
    output logic                 done,
    output rsp_t                 rsp
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FETCH  = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          cmd_reg;
    entry_t              ent_reg;
    logic [SCAN_W-1:0]   scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic                pend_hist_reg, pend_hist_next;
    logic                dup_reg, dup_next;
    logic [QPTR_W-1:0]   head_reg, head_next;
    logic [QCNT_W-1:0]   qfill_reg, qfill_next;
    logic [HCNT_W-1:0]   hfill_reg, hfill_next;
    logic [QCNT_W-1:0]   men_reg, men_next;
    logic [QCNT_W-1:0]   women_reg, women_next;
    logic                done_reg;
    rsp_t                rsp_reg, rsp_next;

    logic                accept;
    logic [SCAN_W-1:0]   total;
    logic                issue;
    logic                in_queue;
    logic [SCAN_W-1:0]   hidx;
    logic [QPTR_W-1:0]   qidx;
    logic [ID_BITS-1:0]  cmp_id;
    logic                match;
    logic [QCNT_W-1:0]   own, other;
    logic [3:0]          status;
    entry_t              moved;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    // scan walk: queue entries first, then history entries
    assign total    = SCAN_W'(qfill_reg) + SCAN_W'(hfill_reg);
    assign issue    = scan_reg < total;
    assign in_queue = scan_reg < SCAN_W'(qfill_reg);
    assign hidx     = scan_reg - SCAN_W'(qfill_reg);
    assign qidx     = qwrap(head_reg, scan_reg[QCNT_W-1:0]);

    // shared id comparator, fed one word per cycle
    assign cmp_id = pend_hist_reg ? hrd.id : qrd.id;
    assign match  = pend_reg && (cmp_id == ent_reg.id);

    assign own   = ent_reg.cls ? women_reg : men_reg;
    assign other = ent_reg.cls ? men_reg : women_reg;

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        pend_hist_next = pend_hist_reg;
        dup_next       = dup_reg;
        qreq           = '0;
        hreq           = '0;
        qreq.raddr     = head_reg;
        hreq.raddr     = hidx[HPTR_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    scan_next = '0;
                    dup_next  = 1'b0;
                    unique case (command)
                        CMD_ADD:              state_next = S_SCAN;
                        CMD_SERVE, CMD_UNDO:  state_next = S_FETCH;
                        default:              state_next = S_DECIDE;
                    endcase
                end
            end
            S_SCAN:
            begin
                dup_next = dup_reg || match;
                if (issue)
                begin
                    qreq.raddr     = qidx;
                    pend_next      = 1'b1;
                    pend_hist_next = !in_queue;
                    scan_next      = scan_reg + SCAN_W'(1);
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_FETCH:
            begin
                hreq.raddr = HPTR_W'(hfill_reg - HCNT_W'(1));
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // outcome of the command, applied only in the decide step
        status     = ST_OK;
        moved      = '0;
        head_next  = head_reg;
        qfill_next = qfill_reg;
        hfill_next = hfill_reg;
        men_next   = men_reg;
        women_next = women_reg;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                priority if (dup_reg)
                    status = ST_DUP;
                else if (ent_reg.age < cfg.min_age)
                    status = ST_YOUNG;
                else if (ent_reg.age > cfg.max_age)
                    status = ST_OLD;
                else if ((own > other) && (GAP_W'(own - other) > GAP_W'(cfg.gap)))
                    status = ST_GAP;
                else if (qfill_reg == QCNT_W'(QUEUE_DEPTH))
                    status = ST_QFULL;
                else
                begin
                    moved       = ent_reg;
                    qreq.waddr  = qwrap(head_reg, qfill_reg);
                    qreq.wdata  = ent_reg;
                    qreq.we     = (state_reg == S_DECIDE);
                    qfill_next  = qfill_reg + QCNT_W'(1);
                    if (ent_reg.cls)
                        women_next = women_reg + QCNT_W'(1);
                    else
                        men_next = men_reg + QCNT_W'(1);
                end
            end
            CMD_SERVE:
            begin
                priority if (qfill_reg == '0)
                    status = ST_QEMPTY;
                else if (hfill_reg == HCNT_W'(HISTORY_DEPTH))
                    status = ST_HFULL;
                else
                begin
                    moved      = qrd;
                    head_next  = qwrap(head_reg, QCNT_W'(1));
                    qfill_next = qfill_reg - QCNT_W'(1);
                    hreq.waddr = hfill_reg[HPTR_W-1:0];
                    hreq.wdata = qrd;
                    hreq.we    = (state_reg == S_DECIDE);
                    hfill_next = hfill_reg + HCNT_W'(1);
                    if (qrd.cls)
                        women_next = women_reg - QCNT_W'(1);
                    else
                        men_next = men_reg - QCNT_W'(1);
                end
            end
            CMD_UNDO:
            begin
                priority if (hfill_reg == '0)
                    status = ST_HEMPTY;
                else if (qfill_reg == QCNT_W'(QUEUE_DEPTH))
                    status = ST_QFULL;
                else
                begin
                    moved      = hrd;
                    hfill_next = hfill_reg - HCNT_W'(1);
                    head_next  = (head_reg == '0) ? QPTR_W'(QUEUE_DEPTH - 1)
                                                  : head_reg - QPTR_W'(1);
                    qreq.waddr = head_next;
                    qreq.wdata = hrd;
                    qreq.we    = (state_reg == S_DECIDE);
                    qfill_next = qfill_reg + QCNT_W'(1);
                    if (hrd.cls)
                        women_next = women_reg + QCNT_W'(1);
                    else
                        men_next = men_reg + QCNT_W'(1);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase

        rsp_next.status  = status;
        rsp_next.moved   = moved;
        rsp_next.waiting = qfill_next;
        rsp_next.history = hfill_next;
        rsp_next.men     = men_next;
        rsp_next.women   = women_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            dup_reg   <= 1'b0;
            scan_reg  <= '0;
            head_reg  <= '0;
            qfill_reg <= '0;
            hfill_reg <= '0;
            men_reg   <= '0;
            women_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            dup_reg   <= dup_next;
            scan_reg  <= scan_next;
            done_reg  <= (state_reg == S_DECIDE);
            if (state_reg == S_DECIDE)
            begin
                head_reg  <= head_next;
                qfill_reg <= qfill_next;
                hfill_reg <= hfill_next;
                men_reg   <= men_next;
                women_reg <= women_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_hist_reg <= pend_hist_next;
        if (accept)
        begin
            cmd_reg     <= command;
            ent_reg.id  <= id_in(entry_id);
            ent_reg.age <= entry_age;
            ent_reg.cls <= entry_class;
        end
        if (state_reg == S_DECIDE)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// File: rtl/service_queue_with_undo_history.sv
// Service queue with undo history. A command is taken when start is high
// and busy is low; its single result word appears for exactly one cycle
// with done high and must be captured then, since the receiver cannot hold
// it off. An add scans every waiting and history entry for a duplicate id
// through one shared comparator, one entry per cycle, before it decides.
// Serve and undo fetch one entry; an unused command code goes straight to
// the decide step. The counts reported with each word are those after the
// command. Configuration writes are always ready and are meant to land
// only while the block is idle.
module service_queue_with_undo_history
    import sqh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            command,
    input  logic [ID_PORT_W-1:0]  entry_id,
    input  logic [AGE_W-1:0]      entry_age,
    input  logic                  entry_class,
    // result channel
    output logic                  done,
    output logic [3:0]            status,
    output logic [ID_PORT_W-1:0]  moved_id,
    output logic [AGE_W-1:0]      moved_age,
    output logic                  moved_class,
    output logic [CNT_PORT_W-1:0] waiting_count,
    output logic [CNT_PORT_W-1:0] history_count,
    output logic [CNT_PORT_W-1:0] men_waiting,
    output logic [CNT_PORT_W-1:0] women_waiting,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [AGE_W-1:0]      cfg_data
);

    cfg_t      cfg_reg;
    qmem_req_t qreq;
    hmem_req_t hreq;
    logic [ENTRY_W-1:0] qrd_raw, hrd_raw;
    rsp_t      rsp;

    // Configuration registers: take every write at once; unknown indexes drop.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_age <= MIN_AGE_RST;
            cfg_reg.max_age <= MAX_AGE_RST;
            cfg_reg.gap     <= GAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_AGE: cfg_reg.min_age <= cfg_data;
                REG_MAX_AGE: cfg_reg.max_age <= cfg_data;
                REG_GAP:     cfg_reg.gap     <= cfg_data[GAP_CFG_W-1:0];
                default:     cfg_reg.gap     <= cfg_reg.gap;
            endcase
        end
    end

    // Sequencer with the shared id comparator, counters and result register.
    sqh_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .entry_id    (entry_id),
        .entry_age   (entry_age),
        .entry_class (entry_class),
        .cfg         (cfg_reg),
        .qreq        (qreq),
        .qrd         (entry_t'(qrd_raw)),
        .hreq        (hreq),
        .hrd         (entry_t'(hrd_raw)),
        .busy        (busy),
        .done        (done),
        .rsp         (rsp)
    );

    // Waiting queue: circular buffer addressed from the head pointer.
    sqh_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_queue_mem (
        .clk   (clk),
        .we    (qreq.we),
        .waddr (qreq.waddr),
        .wdata (qreq.wdata),
        .raddr (qreq.raddr),
        .rdata (qrd_raw)
    );

    // History: a stack whose top is one below the fill count.
    sqh_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_history_mem (
        .clk   (clk),
        .we    (hreq.we),
        .waddr (hreq.waddr),
        .wdata (hreq.wdata),
        .raddr (hreq.raddr),
        .rdata (hrd_raw)
    );

    // Drive the result word from the registered response.
    assign status        = rsp.status;
    assign moved_id      = id_out(rsp.moved.id);
    assign moved_age     = rsp.moved.age;
    assign moved_class   = rsp.moved.cls;
    assign waiting_count = CNT_PORT_W'(rsp.waiting);
    assign history_count = CNT_PORT_W'(rsp.history);
    assign men_waiting   = CNT_PORT_W'(rsp.men);
    assign women_waiting = CNT_PORT_W'(rsp.women);

endmodule

// File: rtl/sqh_checker.sv
`include "assert_macros.svh"

module sqh_checker
    import sqh_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [3:0]            status,
    input logic [ID_PORT_W-1:0]  moved_id,
    input logic [AGE_W-1:0]      moved_age,
    input logic                  moved_class,
    input logic [CNT_PORT_W-1:0] waiting_count,
    input logic [CNT_PORT_W-1:0] men_waiting,
    input logic [CNT_PORT_W-1:0] women_waiting
);

    `SQH_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `SQH_ASSERT_IMPLY(a_done_after_busy, clk, rst_n, done, !busy && $past(busy))
    `SQH_ASSERT_IMPLY(a_status_code, clk, rst_n, done, status <= ST_HFULL)
    `SQH_ASSERT_IMPLY(a_class_sum, clk, rst_n, done,
        6'(waiting_count) == 6'(men_waiting) + 6'(women_waiting))
    `SQH_ASSERT_IMPLY(a_fail_zero, clk, rst_n, done && (status != ST_OK),
        (moved_id == '0) && (moved_age == '0) && !moved_class)

endmodule

bind service_queue_with_undo_history sqh_checker u_sqh_checker (.*);
